### hw/rtl/ta2o_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ta2o_pkg: shared constants and arctangent table for the atan2 core
// Holds the angle constants in Q2.13, pipeline widths and the table builder.
// ---------------------------------------------------------------------------
package ta2o_pkg;

    localparam int TABLE_STEPS = 1024;
    localparam int IN_WIDTH    = 16;
    localparam int ANG_WIDTH   = 16;
    localparam int ROM_WIDTH   = 13;
    localparam int MAG_WIDTH   = IN_WIDTH + 1;
    localparam int QUO_WIDTH   = $clog2(TABLE_STEPS) + 1;
    localparam int DVS_WIDTH   = MAG_WIDTH + 1;
    localparam int REM_WIDTH   = MAG_WIDTH + QUO_WIDTH;
    localparam int DIV_STAGES  = QUO_WIDTH;

    localparam logic signed [ANG_WIDTH-1:0] Q_HALF_PI = 16'sd12868;
    localparam logic signed [ANG_WIDTH-1:0] Q_PI      = 16'sd25736;

    // table step as a ratio, exact for a power-of-two step count
    localparam real STEP_SCALE = 1.0 / real'(TABLE_STEPS);

    typedef logic [ROM_WIDTH-1:0] rom_t [0:TABLE_STEPS];

    // table entry i holds round(8192 * atan(i / TABLE_STEPS))
    function automatic rom_t build_rom();
        rom_t r;
        real  v;
        for (int i = 0; i <= TABLE_STEPS; i++) begin
            v = 8192.0 * $atan(real'(i) * STEP_SCALE) + 0.5;
            r[i] = ROM_WIDTH'($rtoi(v));
        end
        return r;
    endfunction

    localparam rom_t ATAN_ROM = build_rom();

endpackage

### hw/rtl/table_atan2_octant_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_atan2_octant_core: four-quadrant atan2 by octant fold and table
// Folds (y,x) to the first octant, divides in a bit-per-stage pipeline,
// reads the arctangent table and unfolds with pi/2 and pi.
// ---------------------------------------------------------------------------
// pipeline: 14 register stages from input accept to result valid (fold, 11
//   divide stages, table read, unfold), one divide stage per quotient bit
// throughput: one word per cycle; a stalled output holds the whole pipe
// reset: synchronous active-low aresetn clears all valid bits

module table_atan2_octant_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ta2o_pkg::IN_WIDTH-1:0]  s_y_in,
    input  logic signed [ta2o_pkg::IN_WIDTH-1:0]  s_x_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ta2o_pkg::ANG_WIDTH-1:0] m_angle
);

    localparam int MW = ta2o_pkg::MAG_WIDTH;
    localparam int QW = ta2o_pkg::QUO_WIDTH;
    localparam int DW = ta2o_pkg::DVS_WIDTH;
    localparam int RW = ta2o_pkg::REM_WIDTH;
    localparam int NS = ta2o_pkg::DIV_STAGES;
    localparam int AW = ta2o_pkg::ANG_WIDTH;
    localparam int IN_MSB = ta2o_pkg::IN_WIDTH - 1;

    // divider pipe registers, index 0 is the fold stage
    logic [NS+2:0]         vld_reg;
    logic [RW-1:0]         rem_reg  [0:NS];
    logic [QW-1:0]         quo_reg  [0:NS];
    logic [DW-1:0]         dvs_reg  [0:NS];
    logic signed [AW-1:0]  base_reg [0:NS+1];
    logic                  neg_reg  [0:NS+1];
    logic                  zero_reg [0:NS];
    logic [ta2o_pkg::ROM_WIDTH-1:0] rom_reg;
    logic signed [AW-1:0]  angle_reg;

    logic                  adv;

    // fold signals
    logic [MW-1:0]         ay, ax, fa, fb;
    logic signed [AW-1:0]  fbase;
    logic                  fneg;

    // per stage divide step
    logic [RW-1:0]         rem_next [0:NS-1];
    logic [QW-1:0]         quo_next [0:NS-1];
    logic [QW-1:0]         idx;

    assign adv     = !vld_reg[NS+2] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NS+2];
    assign m_angle = angle_reg;

    // octant fold: pick numerator, divisor and unfold constant
    always_comb begin
        ay = s_y_in[IN_MSB] ? MW'(-$signed({s_y_in[IN_MSB], s_y_in})) : MW'(s_y_in);
        ax = s_x_in[IN_MSB] ? MW'(-$signed({s_x_in[IN_MSB], s_x_in})) : MW'(s_x_in);
        fa    = ay;
        fb    = ax;
        fbase = '0;
        fneg  = 1'b0;
        if (!s_y_in[IN_MSB]) begin
            if (!s_x_in[IN_MSB]) begin
                if (ax >= ay) begin
                    fa = ay; fb = ax; fbase = '0; fneg = 1'b0;
                end else begin
                    fa = ax; fb = ay; fbase = ta2o_pkg::Q_HALF_PI; fneg = 1'b1;
                end
            end else begin
                if (ax < ay) begin
                    fa = ax; fb = ay; fbase = ta2o_pkg::Q_HALF_PI; fneg = 1'b0;
                end else begin
                    fa = ay; fb = ax; fbase = ta2o_pkg::Q_PI; fneg = 1'b1;
                end
            end
        end else begin
            if (s_x_in[IN_MSB]) begin
                if (ax >= ay) begin
                    fa = ay; fb = ax; fbase = -ta2o_pkg::Q_PI; fneg = 1'b0;
                end else begin
                    fa = ax; fb = ay; fbase = -ta2o_pkg::Q_HALF_PI; fneg = 1'b1;
                end
            end else begin
                if (ax < ay) begin
                    fa = ax; fb = ay; fbase = -ta2o_pkg::Q_HALF_PI; fneg = 1'b0;
                end else begin
                    fa = ay; fb = ax; fbase = '0; fneg = 1'b1;
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    always_comb begin
        logic [RW-1:0] trial;
        for (int k = 0; k < NS; k++) begin
            trial = RW'(dvs_reg[k]) << (NS - 1 - k);
            if (rem_reg[k] >= trial) begin
                rem_next[k] = rem_reg[k] - trial;
                quo_next[k] = quo_reg[k] | (QW'(1) << (NS - 1 - k));
            end else begin
                rem_next[k] = rem_reg[k];
                quo_next[k] = quo_reg[k];
            end
        end
    end

    // table index, clamped to the last entry
    assign idx = (quo_reg[NS] > QW'(ta2o_pkg::TABLE_STEPS)) ?
                 QW'(ta2o_pkg::TABLE_STEPS) : quo_reg[NS];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS+1:0], s_valid};
        end
    end

    // payload pipe, numerator is 2 * TABLE_STEPS * a + b over 2 * b
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= (RW'(fa) << QW) + RW'(fb);
            quo_reg[0]  <= '0;
            dvs_reg[0]  <= {fb, 1'b0};
            base_reg[0] <= fbase;
            neg_reg[0]  <= fneg;
            zero_reg[0] <= (fb == '0);
            for (int k = 0; k < NS; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                quo_reg[k+1]  <= quo_next[k];
                dvs_reg[k+1]  <= dvs_reg[k];
                base_reg[k+1] <= base_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
            // table read
            rom_reg        <= zero_reg[NS] ? '0 : ta2o_pkg::ATAN_ROM[idx[QW-1:0]];
            base_reg[NS+1] <= base_reg[NS];
            neg_reg[NS+1]  <= neg_reg[NS];
            // unfold
            angle_reg <= neg_reg[NS+1] ? base_reg[NS+1] - $signed(AW'(rom_reg))
                                       : base_reg[NS+1] + $signed(AW'(rom_reg));
        end
    end

endmodule

### test/table_atan2_octant_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_atan2_octant_core_tb: self-checking bench for the atan2 octant core
// Drives (y,x) words with bursty valid and a patterned output stall, predicts
// each angle by octant fold and an arctangent table, and checks results in order.
// ---------------------------------------------------------------------------

// predicts angles for accepted words and checks results in arrival order
class atan2_scoreboard;
    logic signed [15:0] pending_angles[$];
    int unsigned        atan_table[0:1024];
    int                 mismatches;

    function new();
        real v;
        for (int i = 0; i <= 1024; i++) begin
            v = 8192.0 * $atan(real'(i) / 1024.0);
            atan_table[i] = int'($floor(v + 0.5));
        end
        mismatches = 0;
    endfunction

    // table read for a folded ratio a/b, zero divisor gives zero
    function int ratio_angle(longint a, longint b);
        longint idx;
        if (b == 0) return 0;
        idx = (2048 * a + b) / (2 * b);
        if (idx > 1024) idx = 1024;
        return atan_table[idx];
    endfunction

    function void note_pair(logic signed [15:0] y, logic signed [15:0] x);
        longint yv, xv, ay, ax;
        int     ang;
        logic [31:0] bits;
        yv = y;
        xv = x;
        ay = (yv < 0) ? -yv : yv;
        ax = (xv < 0) ? -xv : xv;
        if (yv >= 0) begin
            if (xv >= 0)
                ang = (ax >= ay) ? ratio_angle(ay, ax) : 12868 - ratio_angle(ax, ay);
            else
                ang = (ax < ay) ? 12868 + ratio_angle(ax, ay) : 25736 - ratio_angle(ay, ax);
        end else begin
            if (xv < 0)
                ang = (ax >= ay) ? -25736 + ratio_angle(ay, ax)
                                 : -12868 - ratio_angle(ax, ay);
            else
                ang = (ax < ay) ? -12868 + ratio_angle(ax, ay) : -ratio_angle(ay, ax);
        end
        bits = ang;
        pending_angles.push_back(bits[15:0]);
    endfunction

    function void check_angle(logic signed [15:0] actual);
        logic signed [15:0] want;
        if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: angle %0d", actual);
            return;
        end
        want = pending_angles.pop_front();
        if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("angle error: expected %0d got %0d", want, actual);
        end
    endfunction
endclass

module table_atan2_octant_core_tb;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_y_in;
    logic signed [15:0] s_x_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_angle;

    atan2_scoreboard sb;
    int unsigned     cycle_count;

    table_atan2_octant_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_y_in  (s_y_in),
        .s_x_in  (s_x_in),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_angle (m_angle)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000) begin
            $display("table_atan2_octant_core: mismatch");
            $finish;
        end
    end

    // receiver stall pattern, mode chosen by bits 9:8 of the cycle count
    always @(negedge aclk) begin
        case (cycle_count[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 1) == 1);
            2'd2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycle_count[3:0] < 4'd12);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_angle(m_angle);
    end

    // drive one word and hold it until accepted, returns at the next falling edge
    task automatic send_word(input logic signed [15:0] y, input logic signed [15:0] x);
        s_valid <= 1'b1;
        s_y_in  <= y;
        s_x_in  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pair(y, x);
        @(negedge aclk);
    endtask

    task automatic idle_cycles(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_random_word();
        logic signed [15:0] y, x;
        int                 m;
        y = $urandom;
        x = $urandom;
        case ($urandom_range(0, 5))
            0: begin
                y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                x = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            end
            1: begin
                m = $urandom_range(0, 32768);
                y = ($urandom_range(0, 1) == 1) ? 16'(m) : 16'(-m);
                x = ($urandom_range(0, 1) == 1) ? 16'(m) : 16'(-m);
            end
            2: x = $signed(16'($urandom_range(0, 4))) - 16'sd2;
            3: y = $signed(16'($urandom_range(0, 4))) - 16'sd2;
            default: ;
        endcase
        send_word(y, x);
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_y_in  = '0;
        s_x_in  = '0;
        m_ready = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners: axes, diagonals, zero, most negative values
        send_word(16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd5);
        send_word(16'sd0, -16'sd5);
        send_word(16'sd5, 16'sd0);
        send_word(-16'sd5, 16'sd0);
        send_word(-16'sd32768, 16'sd0);
        send_word(16'sd0, -16'sd32768);
        send_word(-16'sd32768, -16'sd32768);
        send_word(-16'sd32768, 16'sd32767);
        send_word(16'sd32767, -16'sd32768);
        send_word(16'sd32767, 16'sd32767);
        send_word(16'sd7, 16'sd7);
        send_word(16'sd7, -16'sd7);
        send_word(-16'sd7, -16'sd7);
        send_word(-16'sd7, 16'sd7);
        send_word(16'sd1, 16'sd32767);
        send_word(16'sd32767, 16'sd1);
        send_word(-16'sd1, -16'sd32768);
        send_word(16'sd1, -16'sd32768);
        send_word(16'sd100, 16'sd99);
        send_word(-16'sd99, 16'sd100);

        // random bursts and gaps
        for (int n = 0; n < 1450; ) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_random_word();
                n++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
            // drain the pipe once midway
            if (n >= 700 && n < 700 + burst) begin
                s_valid <= 1'b0;
                while (sb.pending_angles.size() != 0) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;

        while (sb.pending_angles.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (sb.mismatches == 0)
            $display("table_atan2_octant_core: match");
        else
            $display("table_atan2_octant_core: mismatch");
        $finish;
    end
endmodule
